// ===== rtl/tic_pkg.sv =====
package tic_pkg;

   localparam int MEM_WORDS = 65536;
   localparam int NUM_REGS  = 32;
   localparam int MEM_AW    = $clog2(MEM_WORDS);
   localparam int REG_AW    = $clog2(NUM_REGS);

   localparam int WORD_W = 32;
   localparam int ADDR_W = 16;
   localparam int IDX_W  = 5;
   localparam int STS_W  = 3;
   localparam int REQ_W  = 2;
   localparam int OP_W   = 8;

   // byte positions inside an instruction word
   localparam int OP_LSB   = 24;
   localparam int DST_LSB  = 16;
   localparam int SRC1_LSB = 8;
   localparam int SRC2_LSB = 0;

   localparam logic [REQ_W-1:0] REQ_MEM_WR = 2'd0;
   localparam logic [REQ_W-1:0] REQ_REG_WR = 2'd1;
   localparam logic [REQ_W-1:0] REQ_EXEC   = 2'd2;
   localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

   localparam logic [STS_W-1:0] STS_OK       = 3'd0;
   localparam logic [STS_W-1:0] STS_HALTED   = 3'd1;
   localparam logic [STS_W-1:0] STS_BAD_OP   = 3'd2;
   localparam logic [STS_W-1:0] STS_BAD_REG  = 3'd3;
   localparam logic [STS_W-1:0] STS_BAD_ADDR = 3'd4;

   localparam logic [OP_W-1:0] OP_ADD   = 8'd1;
   localparam logic [OP_W-1:0] OP_HALT  = 8'd2;
   localparam logic [OP_W-1:0] OP_JUMP  = 8'd3;
   localparam logic [OP_W-1:0] OP_LOAD  = 8'd4;
   localparam logic [OP_W-1:0] OP_STORE = 8'd5;
   localparam logic [OP_W-1:0] OP_BEQ   = 8'd6;

   typedef struct packed {
      logic [STS_W-1:0]  status;
      logic [WORD_W-1:0] pc;
      logic              reg_write_valid;
      logic [IDX_W-1:0]  reg_write_index;
      logic [WORD_W-1:0] reg_write_value;
      logic              mem_write_valid;
      logic [ADDR_W-1:0] mem_write_address;
      logic [WORD_W-1:0] mem_write_value;
   } result_type;

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_FETCH  = 7'b0000100,
      S_EXEC   = 7'b0001000,
      S_LOAD   = 7'b0010000,
      S_BRANCH = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

endpackage

// ===== rtl/tic_chan_if.sv =====
interface tic_req_if import tic_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [ADDR_W-1:0] mem_address;
   logic [IDX_W-1:0]  reg_index;
   logic [WORD_W-1:0] value;

   modport source (output valid, req_type, mem_address, reg_index, value, input ready);
   modport sink   (input valid, req_type, mem_address, reg_index, value, output ready);
endinterface

interface tic_rsp_if import tic_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STS_W-1:0]  status;
   logic [WORD_W-1:0] pc;
   logic              reg_write_valid;
   logic [IDX_W-1:0]  reg_write_index;
   logic [WORD_W-1:0] reg_write_value;
   logic              mem_write_valid;
   logic [ADDR_W-1:0] mem_write_address;
   logic [WORD_W-1:0] mem_write_value;

   modport source (output valid, status, pc, reg_write_valid, reg_write_index,
                   reg_write_value, mem_write_valid, mem_write_address,
                   mem_write_value, input ready);
   modport sink   (input valid, status, pc, reg_write_valid, reg_write_index,
                   reg_write_value, mem_write_valid, mem_write_address,
                   mem_write_value, output ready);
endinterface

// ===== rtl/tiny_isa_core_step.sv =====
// Small processor core driven by host transactions: a transaction writes a memory word,
// writes a register, executes the instruction at the program counter or reports the
// status, and each one returns one result transaction. After reset the core zeroes all
// MEM_WORDS (65536) words of the word memory and takes no request meanwhile; csr writes
// are taken at any time. Host writes finish at the accept edge. Instructions use a
// single-port word memory (fetch, then load/store data) and a two-read register
// file, both with registered reads: add, jump, store and untaken beq finish in the
// execute state, load and taken beq in a further load or branch state, halt and
// decode errors in the fetch state, and a fetch out of range at the accept edge
// itself. Ready returns as the result is registered. A finished result waits in a
// holding register when the result side stalls, so the core keeps one transaction
// in flight at a time.
module tiny_isa_core_step import tic_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   tic_req_if.sink           req_bus,
   tic_rsp_if.source         rsp_bus,
   input  logic              csr_we,
   input  logic [ADDR_W-1:0] csr_wdata
);

   state_type         state_ff, state_in;
   logic [MEM_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [WORD_W-1:0] pc_ff, pc_in;
   logic              halted_ff, halted_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [REG_AW-1:0] dst_ff, dst_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;
   result_type        hold_ff, hold_in;
   logic [NUM_REGS-1:0] rf_vld_ff, rf_vld_in;

   // word memory, single port
   logic [WORD_W-1:0] word_mem [MEM_WORDS];
   logic              mem_we;
   logic [MEM_AW-1:0] mem_addr;
   logic [WORD_W-1:0] mem_wdata;
   logic [WORD_W-1:0] mem_rd_ff;

   // register file, one write and two read ports
   logic [WORD_W-1:0] reg_mem [NUM_REGS];
   logic              rf_we;
   logic [REG_AW-1:0] rf_waddr;
   logic [WORD_W-1:0] rf_wdata;
   logic [REG_AW-1:0] rfa_addr, rfb_addr;
   logic [WORD_W-1:0] rfa_rd_ff, rfb_rd_ff;
   logic              rfa_vld_ff, rfb_vld_ff;
   logic [WORD_W-1:0] rfa, rfb;

   logic accept;
   logic out_free;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // entries never written since reset read as zero
   assign rfa = rfa_vld_ff ? rfa_rd_ff : '0;
   assign rfb = rfb_vld_ff ? rfb_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         word_mem[mem_addr] <= mem_wdata;
      end
      mem_rd_ff <= word_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         reg_mem[rf_waddr] <= rf_wdata;
      end
      rfa_rd_ff  <= reg_mem[rfa_addr];
      rfb_rd_ff  <= reg_mem[rfb_addr];
      rfa_vld_ff <= rf_vld_ff[rfa_addr];
      rfb_vld_ff <= rf_vld_ff[rfb_addr];
   end

   always_comb begin
      logic [WORD_W-1:0] word;
      logic [OP_W-1:0]   f_op;
      logic [OP_W-1:0]   f_dst;
      logic [OP_W-1:0]   f_src1;
      logic [OP_W-1:0]   f_src2;
      logic [2:0]        used;
      logic              bad_op;
      logic              bad_reg;
      logic              fin;
      result_type        res;

      word   = mem_rd_ff;
      f_op   = word[OP_LSB +: OP_W];
      f_dst  = word[DST_LSB +: OP_W];
      f_src1 = word[SRC1_LSB +: OP_W];
      f_src2 = word[SRC2_LSB +: OP_W];
      used   = 3'b000;
      bad_op = 1'b0;
      fin    = 1'b0;
      res    = '0;

      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      pc_in      = pc_ff;
      halted_in  = halted_ff;
      op_in      = op_ff;
      dst_in     = dst_ff;
      hold_in    = hold_ff;
      rf_vld_in  = rf_vld_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      mem_we    = 1'b0;
      mem_addr  = MEM_AW'(pc_ff);
      mem_wdata = '0;
      rf_we     = 1'b0;
      rf_waddr  = dst_ff;
      rf_wdata  = '0;
      rfa_addr  = REG_AW'(f_src1);
      rfb_addr  = REG_AW'(f_src2);

      // operand bytes used by each opcode: bit0 dst, bit1 src1, bit2 src2
      unique case (f_op)
         OP_ADD:   used = 3'b111;
         OP_HALT:  used = 3'b000;
         OP_JUMP:  used = 3'b001;
         OP_LOAD:  used = 3'b011;
         OP_STORE: used = 3'b011;
         OP_BEQ:   used = 3'b111;
         default:  bad_op = 1'b1;
      endcase
      bad_reg = (used[0] && (32'(f_dst)  >= 32'(NUM_REGS))) ||
                (used[1] && (32'(f_src1) >= 32'(NUM_REGS))) ||
                (used[2] && (32'(f_src2) >= 32'(NUM_REGS)));

      unique case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_addr   = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == MEM_AW'(MEM_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_bus.req_type)
                  REQ_MEM_WR: begin
                     fin = 1'b1;
                     if (32'(req_bus.mem_address) < 32'(MEM_WORDS)) begin
                        mem_we    = 1'b1;
                        mem_addr  = MEM_AW'(req_bus.mem_address);
                        mem_wdata = req_bus.value;
                     end else begin
                        res.status = STS_BAD_ADDR;
                     end
                  end
                  REQ_REG_WR: begin
                     fin = 1'b1;
                     if (32'(req_bus.reg_index) < 32'(NUM_REGS)) begin
                        rf_we     = 1'b1;
                        rf_waddr  = REG_AW'(req_bus.reg_index);
                        rf_wdata  = req_bus.value;
                        rf_vld_in[REG_AW'(req_bus.reg_index)] = 1'b1;
                     end else begin
                        res.status = STS_BAD_REG;
                     end
                  end
                  REQ_EXEC: begin
                     priority if (halted_ff) begin
                        fin        = 1'b1;
                        res.status = STS_HALTED;
                     end else if (pc_ff >= 32'(MEM_WORDS)) begin
                        fin        = 1'b1;
                        halted_in  = 1'b1;
                        res.status = STS_BAD_ADDR;
                     end else begin
                        mem_addr = MEM_AW'(pc_ff);
                        state_in = S_FETCH;
                     end
                  end
                  REQ_NONE: begin
                     fin        = 1'b1;
                     res.status = halted_ff ? STS_HALTED : STS_OK;
                  end
                  default: fin = 1'b1;
               endcase
            end
         end
         S_FETCH: begin
            // jump reads its target on port a, store its data on port b
            rfa_addr = (f_op == OP_JUMP)  ? REG_AW'(f_dst) : REG_AW'(f_src1);
            rfb_addr = (f_op == OP_STORE) ? REG_AW'(f_dst) : REG_AW'(f_src2);
            op_in    = f_op;
            dst_in   = REG_AW'(f_dst);
            priority if (bad_op) begin
               fin        = 1'b1;
               halted_in  = 1'b1;
               res.status = STS_BAD_OP;
            end else if (bad_reg) begin
               fin        = 1'b1;
               halted_in  = 1'b1;
               res.status = STS_BAD_REG;
            end else if (f_op == OP_HALT) begin
               fin        = 1'b1;
               halted_in  = 1'b1;
               res.status = STS_HALTED;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (op_ff)
               OP_ADD: begin
                  fin      = 1'b1;
                  rf_we    = 1'b1;
                  rf_wdata = rfa + rfb;
                  rf_vld_in[dst_ff] = 1'b1;
                  res.reg_write_valid = 1'b1;
                  res.reg_write_index = IDX_W'(dst_ff);
                  res.reg_write_value = rfa + rfb;
                  pc_in = pc_ff + 1'b1;
               end
               OP_JUMP: begin
                  fin   = 1'b1;
                  pc_in = rfa;
               end
               OP_LOAD, OP_STORE: begin
                  priority if (rfa >= 32'(MEM_WORDS)) begin
                     fin        = 1'b1;
                     halted_in  = 1'b1;
                     res.status = STS_BAD_ADDR;
                  end else if (op_ff == OP_LOAD) begin
                     mem_addr = MEM_AW'(rfa);
                     state_in = S_LOAD;
                  end else begin
                     fin       = 1'b1;
                     mem_we    = 1'b1;
                     mem_addr  = MEM_AW'(rfa);
                     mem_wdata = rfb;
                     res.mem_write_valid   = 1'b1;
                     res.mem_write_address = rfa[ADDR_W-1:0];
                     res.mem_write_value   = rfb;
                     pc_in = pc_ff + 1'b1;
                  end
               end
               OP_BEQ: begin
                  if (rfa == rfb) begin
                     rfa_addr = dst_ff;
                     state_in = S_BRANCH;
                  end else begin
                     fin   = 1'b1;
                     pc_in = pc_ff + 1'b1;
                  end
               end
               default: fin = 1'b1;
            endcase
         end
         S_LOAD: begin
            fin      = 1'b1;
            rf_we    = 1'b1;
            rf_wdata = mem_rd_ff;
            rf_vld_in[dst_ff] = 1'b1;
            res.reg_write_valid = 1'b1;
            res.reg_write_index = IDX_W'(dst_ff);
            res.reg_write_value = mem_rd_ff;
            pc_in = pc_ff + 1'b1;
         end
         S_BRANCH: begin
            fin   = 1'b1;
            pc_in = rfa;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hold_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      res.pc = pc_in;
      if (fin) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res;
            state_in     = S_IDLE;
         end else begin
            hold_in  = res;
            state_in = S_DONE;
         end
      end

      if (csr_we) begin
         pc_in = WORD_W'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rf_vld_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
         rf_vld_ff    <= rf_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      dst_ff      <= dst_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.status            = rsp_data_ff.status;
   assign rsp_bus.pc                = rsp_data_ff.pc;
   assign rsp_bus.reg_write_valid   = rsp_data_ff.reg_write_valid;
   assign rsp_bus.reg_write_index   = rsp_data_ff.reg_write_index;
   assign rsp_bus.reg_write_value   = rsp_data_ff.reg_write_value;
   assign rsp_bus.mem_write_valid   = rsp_data_ff.mem_write_valid;
   assign rsp_bus.mem_write_address = rsp_data_ff.mem_write_address;
   assign rsp_bus.mem_write_value   = rsp_data_ff.mem_write_value;

endmodule

// ===== sim/tiny_isa_core_step_tb.sv =====
`timescale 1ns / 100ps

module tiny_isa_core_step_tb;
   import tic_pkg::*;

   typedef enum int {
      STOP_BY_HALT,
      STOP_BY_OPCODE,
      STOP_BY_REGISTER,
      STOP_BY_ADDRESS,
      STOP_BY_FETCH
   } stop_kind_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   logic [ADDR_W-1:0] csr_wdata;

   tic_req_if req_if ();
   tic_rsp_if rsp_if ();

   tiny_isa_core_step dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // shadow copy of the architectural state
   logic [WORD_W-1:0] shadow_pc;
   logic [WORD_W-1:0] shadow_regs [NUM_REGS];
   logic [WORD_W-1:0] shadow_mem [MEM_WORDS];
   logic              shadow_halted;

   result_type        expected_results [$];
   int unsigned       mismatches = 0;
   int unsigned       gap_pct;
   int unsigned       stall_pct;
   int unsigned       phase_items;
   logic [ADDR_W-1:0] last_data_addr;

   function automatic result_type core_step_predict(input logic [REQ_W-1:0]  kind,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [IDX_W-1:0]  idx,
                                                    input logic [WORD_W-1:0] data);
      result_type        res;
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] ea;
      logic [OP_W-1:0]   op;
      logic [OP_W-1:0]   rd;
      logic [OP_W-1:0]   ra;
      logic [OP_W-1:0]   rb;
      logic [2:0]        uses;
      logic              known;
      res = '0;
      case (kind)
         REQ_MEM_WR: begin
            if (addr < MEM_WORDS) shadow_mem[addr] = data;
            else res.status = STS_BAD_ADDR;
         end
         REQ_REG_WR: begin
            if (idx < NUM_REGS) shadow_regs[idx] = data;
            else res.status = STS_BAD_REG;
         end
         REQ_EXEC: begin
            if (shadow_halted) begin
               res.status = STS_HALTED;
            end else if (shadow_pc >= MEM_WORDS) begin
               res.status = STS_BAD_ADDR;
               shadow_halted = 1'b1;
            end else begin
               word = shadow_mem[shadow_pc[MEM_AW-1:0]];
               op = word[OP_LSB +: OP_W];
               rd = word[DST_LSB +: OP_W];
               ra = word[SRC1_LSB +: OP_W];
               rb = word[SRC2_LSB +: OP_W];
               known = 1'b1;
               // operand use mask: bit 0 dst, bit 1 src1, bit 2 src2
               case (op)
                  OP_ADD, OP_BEQ:     uses = 3'b111;
                  OP_HALT:            uses = 3'b000;
                  OP_JUMP:            uses = 3'b001;
                  OP_LOAD, OP_STORE:  uses = 3'b011;
                  default: begin
                     uses = 3'b000;
                     known = 1'b0;
                  end
               endcase
               if (!known) begin
                  res.status = STS_BAD_OP;
                  shadow_halted = 1'b1;
               end else if ((uses[0] && rd >= NUM_REGS) || (uses[1] && ra >= NUM_REGS) ||
                            (uses[2] && rb >= NUM_REGS)) begin
                  res.status = STS_BAD_REG;
                  shadow_halted = 1'b1;
               end else begin
                  case (op)
                     OP_ADD: begin
                        res.reg_write_value = shadow_regs[ra[REG_AW-1:0]] +
                                              shadow_regs[rb[REG_AW-1:0]];
                        res.reg_write_valid = 1'b1;
                        res.reg_write_index = rd[IDX_W-1:0];
                        shadow_regs[rd[REG_AW-1:0]] = res.reg_write_value;
                        shadow_pc = shadow_pc + 1;
                     end
                     OP_HALT: begin
                        res.status = STS_HALTED;
                        shadow_halted = 1'b1;
                     end
                     OP_JUMP: shadow_pc = shadow_regs[rd[REG_AW-1:0]];
                     OP_LOAD, OP_STORE: begin
                        ea = shadow_regs[ra[REG_AW-1:0]];
                        if (ea >= MEM_WORDS) begin
                           res.status = STS_BAD_ADDR;
                           shadow_halted = 1'b1;
                        end else if (op == OP_LOAD) begin
                           res.reg_write_value = shadow_mem[ea[MEM_AW-1:0]];
                           res.reg_write_valid = 1'b1;
                           res.reg_write_index = rd[IDX_W-1:0];
                           shadow_regs[rd[REG_AW-1:0]] = res.reg_write_value;
                           shadow_pc = shadow_pc + 1;
                        end else begin
                           res.mem_write_value = shadow_regs[rd[REG_AW-1:0]];
                           res.mem_write_valid = 1'b1;
                           res.mem_write_address = ea[ADDR_W-1:0];
                           shadow_mem[ea[MEM_AW-1:0]] = res.mem_write_value;
                           shadow_pc = shadow_pc + 1;
                        end
                     end
                     default: begin
                        if (shadow_regs[ra[REG_AW-1:0]] == shadow_regs[rb[REG_AW-1:0]])
                           shadow_pc = shadow_regs[rd[REG_AW-1:0]];
                        else
                           shadow_pc = shadow_pc + 1;
                     end
                  endcase
               end
            end
         end
         default: res.status = shadow_halted ? STS_HALTED : STS_OK;
      endcase
      res.pc = shadow_pc;
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] pick_target();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return ADDR_W'($urandom);
      endcase
   endfunction

   // always entered and left at a falling edge; valid stays up for a back-to-back transaction
   task automatic send_item(input logic [REQ_W-1:0]  kind,
                            input logic [ADDR_W-1:0] addr,
                            input logic [IDX_W-1:0]  idx,
                            input logic [WORD_W-1:0] data);
      while ($urandom_range(99) < gap_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.req_type    <= kind;
      req_if.mem_address <= addr;
      req_if.reg_index   <= idx;
      req_if.value       <= data;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_results.push_back(core_step_predict(kind, addr, idx, data));
      phase_items++;
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic program_entry(input logic [ADDR_W-1:0] entry);
      wait_drain();
      csr_we    <= 1'b1;
      csr_wdata <= entry;
      @(negedge clock);
      csr_we <= 1'b0;
      shadow_pc = {{(WORD_W-ADDR_W){1'b0}}, entry};
   endtask

   task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      send_item(REQ_REG_WR, ADDR_W'($urandom), idx, data);
   endtask

   task automatic send_exec();
      send_item(REQ_EXEC, ADDR_W'($urandom), IDX_W'($urandom), $urandom);
   endtask

   task automatic send_none();
      send_item(REQ_NONE, ADDR_W'($urandom), IDX_W'($urandom), $urandom);
   endtask

   // place the instruction at the current pc, then step it
   task automatic run_instr(input logic [OP_W-1:0] op, input logic [OP_W-1:0] rd,
                            input logic [OP_W-1:0] ra, input logic [OP_W-1:0] rb);
      send_item(REQ_MEM_WR, shadow_pc[ADDR_W-1:0], IDX_W'($urandom), {op, rd, ra, rb});
      send_exec();
   endtask

   task automatic rand_instr();
      logic [OP_W-1:0]   op;
      logic [OP_W-1:0]   rd;
      logic [OP_W-1:0]   ra;
      logic [OP_W-1:0]   rb;
      logic [ADDR_W-1:0] target;
      int unsigned       pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         set_reg(IDX_W'($urandom), $urandom);
      end else if (pick < 16) begin
         target = ADDR_W'($urandom);
         send_item(REQ_MEM_WR, target, IDX_W'($urandom), $urandom);
         last_data_addr = target;
      end else if (pick < 19) begin
         send_none();
      end
      rd = OP_W'($urandom_range(NUM_REGS-1));
      ra = OP_W'($urandom_range(NUM_REGS-1));
      rb = OP_W'($urandom_range(NUM_REGS-1));
      case ($urandom_range(9))
         0, 1, 2: op = OP_ADD;
         3:       op = OP_JUMP;
         4, 5:    op = OP_LOAD;
         6, 7:    op = OP_STORE;
         default: op = OP_BEQ;
      endcase
      // pc must not step past the last word
      if (shadow_pc == MEM_WORDS-1) op = OP_JUMP;
      case (op)
         OP_JUMP: begin
            ra = OP_W'($urandom_range(255));
            rb = OP_W'($urandom_range(255));
            if (shadow_regs[rd[REG_AW-1:0]] >= MEM_WORDS || $urandom_range(2) == 0)
               set_reg(rd[IDX_W-1:0], WORD_W'(pick_target()));
         end
         OP_LOAD, OP_STORE: begin
            rb = OP_W'($urandom_range(255));
            if (shadow_regs[ra[REG_AW-1:0]] >= MEM_WORDS || $urandom_range(1))
               set_reg(ra[IDX_W-1:0],
                       WORD_W'($urandom_range(1) ? last_data_addr : pick_target()));
            if (op == OP_STORE) last_data_addr = shadow_regs[ra[REG_AW-1:0]][ADDR_W-1:0];
         end
         OP_BEQ: begin
            if ($urandom_range(1)) begin
               target = pick_target();
               set_reg(ra[IDX_W-1:0], {{(WORD_W-ADDR_W){1'b0}}, target});
               set_reg(rb[IDX_W-1:0], {{(WORD_W-ADDR_W){1'b0}}, target});
            end
            if (shadow_regs[rd[REG_AW-1:0]] >= MEM_WORDS)
               set_reg(rd[IDX_W-1:0], WORD_W'(pick_target()));
         end
         default: ;
      endcase
      run_instr(op, rd, ra, rb);
   endtask

   task automatic test_directed();
      gap_pct = 0;
      stall_pct = 0;
      send_item(REQ_NONE, '1, '1, '1);
      set_reg(5'd0, 32'hFFFF_FFFF);
      set_reg(5'd31, 32'h0000_0001);
      set_reg(5'd1, 32'h0000_FFFF);
      send_item(REQ_MEM_WR, 16'hFFFF, 5'd0, 32'hFFFF_FFFF);
      // wraps to zero
      run_instr(OP_ADD, 8'd2, 8'd0, 8'd31);
      // unused operand bytes carry out-of-range indexes
      run_instr(OP_STORE, 8'd0, 8'd1, 8'hFF);
      run_instr(OP_LOAD, 8'd3, 8'd1, 8'hFF);
      set_reg(5'd4, 32'h0000_0010);
      run_instr(OP_BEQ, 8'd4, 8'd0, 8'd3);
      run_instr(OP_BEQ, 8'd4, 8'd0, 8'd31);
      run_instr(OP_JUMP, 8'd1, 8'hFF, 8'hFF);
      run_instr(OP_JUMP, 8'd2, 8'hFF, 8'hFF);
   endtask

   task automatic test_random_phase(input int unsigned gaps, input int unsigned stalls,
                                    input logic [ADDR_W-1:0] entry, input int unsigned n_items);
      logic paused;
      program_entry(entry);
      gap_pct = gaps;
      stall_pct = stalls;
      phase_items = 0;
      paused = 1'b0;
      while (phase_items < n_items) begin
         rand_instr();
         if ((!paused && phase_items > n_items / 2) || $urandom_range(63) == 0) begin
            wait_drain();
            paused = 1'b1;
         end
      end
   endtask

   // the core stays halted for the rest of the run, so this comes last
   task automatic test_halt_and_after();
      stop_kind_type   how;
      logic [OP_W-1:0] op;
      logic [OP_W-1:0] rd;
      logic [OP_W-1:0] ra;
      logic [OP_W-1:0] rb;
      logic [OP_W-1:0] bad;
      int unsigned     slot;
      gap_pct = 12;
      stall_pct = 12;
      how = stop_kind_type'($urandom_range(4));
      rd = OP_W'($urandom_range(NUM_REGS-1));
      ra = OP_W'($urandom_range(NUM_REGS-1));
      rb = OP_W'($urandom_range(NUM_REGS-1));
      case (how)
         STOP_BY_HALT: run_instr(OP_HALT, OP_W'($urandom), OP_W'($urandom), OP_W'($urandom));
         STOP_BY_OPCODE: begin
            op = OP_W'($urandom_range(249));
            if (op != 0) op = op + 8'd6;
            run_instr(op, OP_W'($urandom), OP_W'($urandom), OP_W'($urandom));
         end
         STOP_BY_REGISTER: begin
            case ($urandom_range(4))
               0:       op = OP_ADD;
               1:       op = OP_BEQ;
               2:       op = OP_JUMP;
               3:       op = OP_LOAD;
               default: op = OP_STORE;
            endcase
            if (op == OP_JUMP) begin
               ra = OP_W'($urandom_range(255));
               rb = OP_W'($urandom_range(255));
               slot = 0;
            end else if (op == OP_LOAD || op == OP_STORE) begin
               rb = OP_W'($urandom_range(255));
               slot = $urandom_range(1);
            end else begin
               slot = $urandom_range(2);
            end
            bad = OP_W'($urandom_range(255, NUM_REGS));
            case (slot)
               0:       rd = bad;
               1:       ra = bad;
               default: rb = bad;
            endcase
            run_instr(op, rd, ra, rb);
         end
         STOP_BY_ADDRESS: begin
            op = $urandom_range(1) ? OP_LOAD : OP_STORE;
            set_reg(ra[IDX_W-1:0], $urandom | (32'h1 << $urandom_range(31, 16)));
            run_instr(op, rd, ra, OP_W'($urandom));
         end
         default: begin
            if ($urandom_range(1)) begin
               set_reg(rd[IDX_W-1:0], $urandom | (32'h1 << $urandom_range(31, 16)));
               run_instr(OP_JUMP, rd, OP_W'($urandom), OP_W'($urandom));
            end else begin
               // stepping off the top of memory
               program_entry(16'hFFFF);
               run_instr(OP_ADD, rd, ra, rb);
            end
            send_exec();
         end
      endcase
      send_exec();
      send_none();
      send_item(REQ_MEM_WR, ADDR_W'($urandom), IDX_W'($urandom), $urandom);
      set_reg(IDX_W'($urandom), $urandom);
      // a new entry moves pc but the core stays halted
      program_entry(ADDR_W'($urandom));
      send_exec();
      send_none();
   endtask

   task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   always @(negedge clock) rsp_if.ready <= ($urandom_range(99) >= stall_pct);

   // sample at the rising edge, compare at the falling edge once the prediction is queued
   always begin : result_check
      result_type got;
      result_type want;
      @(posedge clock);
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.status            = rsp_if.status;
         got.pc                = rsp_if.pc;
         got.reg_write_valid   = rsp_if.reg_write_valid;
         got.reg_write_index   = rsp_if.reg_write_index;
         got.reg_write_value   = rsp_if.reg_write_value;
         got.mem_write_valid   = rsp_if.mem_write_valid;
         got.mem_write_address = rsp_if.mem_write_address;
         got.mem_write_value   = rsp_if.mem_write_value;
         @(negedge clock);
         if (expected_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result transaction, status %0d pc %h",
                     $time, got.status, got.pc);
         end else begin
            want = expected_results.pop_front();
            compare_field("status", WORD_W'(want.status), WORD_W'(got.status));
            compare_field("pc", want.pc, got.pc);
            compare_field("reg_write_valid", WORD_W'(want.reg_write_valid),
                          WORD_W'(got.reg_write_valid));
            compare_field("reg_write_index", WORD_W'(want.reg_write_index),
                          WORD_W'(got.reg_write_index));
            compare_field("reg_write_value", want.reg_write_value, got.reg_write_value);
            compare_field("mem_write_valid", WORD_W'(want.mem_write_valid),
                          WORD_W'(got.mem_write_valid));
            compare_field("mem_write_address", WORD_W'(want.mem_write_address),
                          WORD_W'(got.mem_write_address));
            compare_field("mem_write_value", want.mem_write_value, got.mem_write_value);
         end
      end
   end

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.req_type    = REQ_NONE;
      req_if.mem_address = '0;
      req_if.reg_index   = '0;
      req_if.value       = '0;
      gap_pct            = 0;
      stall_pct          = 0;
      phase_items        = 0;
      last_data_addr     = '0;
      shadow_pc          = '0;
      shadow_halted      = 1'b0;
      for (int i = 0; i < NUM_REGS; i++) shadow_regs[i] = '0;
      for (int i = 0; i < MEM_WORDS; i++) shadow_mem[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_phase(0, 0, 16'hFFFF, 300);
      test_random_phase(61, 0, 16'h0000, 300);
      test_random_phase(0, 61, ADDR_W'($urandom), 300);
      test_random_phase(12, 12, ADDR_W'($urandom), 300);
      test_halt_and_after();
      wait_drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // covers the memory clearing pass after reset with a wide margin
   initial begin
      #4000000;
      $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
